@@ rtl/button_auto_repeat_direction_resolver_assert.svh @@
// Assertion macros shared by the button scanner RTL.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef BUTTON_AUTO_REPEAT_DIRECTION_RESOLVER_ASSERT_SVH
`define BUTTON_AUTO_REPEAT_DIRECTION_RESOLVER_ASSERT_SVH

// Condition holds at every sampled edge
`define BARDR_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BARDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bardr_pkg.sv @@
package bardr_pkg;

    // Fixed field widths
    localparam int MAP_W      = 32;
    localparam int DELAY_W    = 16;
    localparam int INTERVAL_W = 8;
    localparam int BIDX_W     = 6;
    localparam int DIR_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_IDX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_IDX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_IDX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UP_IDX      = 3'd5;

    // Register values after reset
    localparam logic [DELAY_W-1:0]    RST_START_DELAY = 16'd23;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL    = 8'd4;
    localparam logic [BIDX_W-1:0]     RST_DOWN_IDX    = 6'd0;
    localparam logic [BIDX_W-1:0]     RST_LEFT_IDX    = 6'd1;
    localparam logic [BIDX_W-1:0]     RST_RIGHT_IDX   = 6'd2;
    localparam logic [BIDX_W-1:0]     RST_UP_IDX      = 6'd3;

    // Keypad direction codes
    localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd6;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd7;
    localparam logic [DIR_W-1:0] DIR_UP         = 4'd8;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd9;

    // Scan sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DIR  = 5'b10000
    } t_state;

    // Remainder unit status towards the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_status;

endpackage

@@ rtl/bardr_rem_unit.sv @@
module bardr_rem_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [COUNT_WIDTH-1:0]              i_dividend,
    input  logic [bardr_pkg::INTERVAL_W-1:0]    i_divisor,
    output bardr_pkg::t_rem_status              o_status
);

    localparam int STEP_BITS = 4;
    localparam int STEPS     = (COUNT_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int DSH_W     = STEPS * STEP_BITS;
    localparam int CYC_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IW        = bardr_pkg::INTERVAL_W;

    logic [DSH_W-1:0] r_dsh;
    logic [IW-1:0]    r_rem;
    logic [CYC_W-1:0] r_cyc;
    logic             r_busy;
    logic             r_done;
    logic [IW-1:0]    n_rem;
    logic [IW:0]      trial;

    // Restoring remainder steps, one dividend bit each, most significant first
    always_comb begin
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            trial = {n_rem, r_dsh[DSH_W-1-k]};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[IW-1:0];
        end
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cyc  <= '0;
            end else if (r_busy) begin
                r_cyc <= r_cyc + CYC_W'(1);
                if (r_cyc == CYC_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold the shifted dividend and the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsh <= DSH_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_dsh <= r_dsh << STEP_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

@@ rtl/button_auto_repeat_direction_resolver.sv @@
// Button auto-repeat scanner with keypad direction resolver.
// Input channel: i_in_valid / o_in_stall carry one frame tick with the
// held-button bitmap i_held_map. Output channel: o_out_valid / i_out_stall
// carry one result per tick: pressed, triggered, repeated and released maps
// plus the 4-way and 8-way keypad codes.
// Per-button hold counters live in a one-port synchronous memory. Each tick
// sweeps the buttons in order: read, update and write back, and, when a
// repeat may fall due, a 4-bit-per-cycle remainder against the interval.
// The next request can be taken in the cycle the result is presented.
// o_in_stall is high while a tick is in progress. A finished result waits in
// the output register while i_out_stall is high; the next tick still runs and
// only its final cycle waits for the register to free.
// Reset clears all counters (per-entry valid bits), the sequencer and the
// output valid, and loads the default configuration. Write configuration
// through i_cfg_we / i_cfg_idx / i_cfg_data only while idle.
`include "button_auto_repeat_direction_resolver_assert.svh"

module button_auto_repeat_direction_resolver #(
    parameter int NUM_BUTTONS = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bardr_pkg::MAP_W-1:0]         i_held_map,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bardr_pkg::MAP_W-1:0]         o_pressed_map,
    output logic [bardr_pkg::MAP_W-1:0]         o_triggered_map,
    output logic [bardr_pkg::MAP_W-1:0]         o_repeated_map,
    output logic [bardr_pkg::MAP_W-1:0]         o_released_map,
    output logic [bardr_pkg::DIR_W-1:0]         o_dir_four,
    output logic [bardr_pkg::DIR_W-1:0]         o_dir_eight,
    input  logic                                i_cfg_we,
    input  logic [bardr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bardr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int MAP_W   = bardr_pkg::MAP_W;
    localparam int IDX_W   = $clog2(NUM_BUTTONS);
    localparam int BTN_W   = $clog2(NUM_BUTTONS + 1);
    localparam int MATCH_W = (BTN_W > bardr_pkg::BIDX_W) ? BTN_W : bardr_pkg::BIDX_W;
    localparam int CMP_W   = (COUNT_WIDTH > bardr_pkg::DELAY_W) ? COUNT_WIDTH
                                                                : bardr_pkg::DELAY_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [BTN_W-1:0]       LAST_BTN  = BTN_W'(NUM_BUTTONS - 1);

    // Configuration
    logic [bardr_pkg::DELAY_W-1:0]    r_delay;
    logic [bardr_pkg::INTERVAL_W-1:0] r_interval;
    logic [bardr_pkg::BIDX_W-1:0]     r_dir_idx [4];

    // Sequencer
    bardr_pkg::t_state r_state;
    bardr_pkg::t_state n_state;
    logic [BTN_W-1:0]  r_btn;
    logic              r_out_valid;

    // Counter memory and its valid bits
    logic [COUNT_WIDTH-1:0] r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    // Per-tick working set
    logic [MAP_W-1:0]       r_held;
    logic [MAP_W-1:0]       r_pressed;
    logic [MAP_W-1:0]       r_trig;
    logic [MAP_W-1:0]       r_rep;
    logic [MAP_W-1:0]       r_rel;
    logic [COUNT_WIDTH-1:0] r_age [4];

    // Output register
    logic [MAP_W-1:0]              r_o_pressed;
    logic [MAP_W-1:0]              r_o_trig;
    logic [MAP_W-1:0]              r_o_rep;
    logic [MAP_W-1:0]              r_o_rel;
    logic [bardr_pkg::DIR_W-1:0]   r_o_dir4;
    logic [bardr_pkg::DIR_W-1:0]   r_o_dir8;

    logic                   in_acc;
    logic                   out_free;
    logic [IDX_W-1:0]       btn_idx;
    logic [COUNT_WIDTH-1:0] cnt_old;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                   rel_now;
    logic                   need_div;
    logic                   advance;
    logic                   last_btn;
    logic                   mem_we;
    logic [MAP_W-1:0]       bit_mask;
    bardr_pkg::t_rem_status rem_status;

    logic                          a_dn, a_lf, a_rt, a_up, opposed;
    logic                          sel01, sel23, selA, nz01, nz23;
    logic [COUNT_WIDTH-1:0]        age01, age23;
    logic [bardr_pkg::DIR_W-1:0]   code01, code23, dir4, dir8;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign btn_idx  = r_btn[IDX_W-1:0];
    assign last_btn = (r_btn == LAST_BTN);
    assign bit_mask = {{(MAP_W - 1){1'b0}}, 1'b1} << r_btn;
    assign mem_we   = (r_state == bardr_pkg::S_UPD);

    // Count update for the button in hand
    assign cnt_old = r_rd_vld ? r_rd_data : '0;
    assign n_cnt   = r_held[0] ? ((cnt_old == COUNT_MAX) ? cnt_old
                                                         : cnt_old + COUNT_WIDTH'(1))
                               : '0;
    assign rel_now = !r_held[0] && (cnt_old != '0);
    assign need_div = (n_cnt > COUNT_WIDTH'(1)) && (r_interval != '0)
                   && (CMP_W'(n_cnt) >= CMP_W'(r_delay)) && (n_cnt != COUNT_MAX);

    assign advance = ((r_state == bardr_pkg::S_UPD) && !need_div)
                  || ((r_state == bardr_pkg::S_DIV) && rem_status.done);

    bardr_rem_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mem_we && need_div),
        .i_dividend (n_cnt),
        .i_divisor  (r_interval),
        .o_status   (rem_status)
    );

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= bardr_pkg::RST_START_DELAY;
            r_interval   <= bardr_pkg::RST_INTERVAL;
            r_dir_idx[0] <= bardr_pkg::RST_DOWN_IDX;
            r_dir_idx[1] <= bardr_pkg::RST_LEFT_IDX;
            r_dir_idx[2] <= bardr_pkg::RST_RIGHT_IDX;
            r_dir_idx[3] <= bardr_pkg::RST_UP_IDX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bardr_pkg::REG_START_DELAY: r_delay <= i_cfg_data;
                bardr_pkg::REG_INTERVAL:
                    r_interval <= i_cfg_data[bardr_pkg::INTERVAL_W-1:0];
                bardr_pkg::REG_DOWN_IDX:
                    r_dir_idx[0] <= i_cfg_data[bardr_pkg::BIDX_W-1:0];
                bardr_pkg::REG_LEFT_IDX:
                    r_dir_idx[1] <= i_cfg_data[bardr_pkg::BIDX_W-1:0];
                bardr_pkg::REG_RIGHT_IDX:
                    r_dir_idx[2] <= i_cfg_data[bardr_pkg::BIDX_W-1:0];
                bardr_pkg::REG_UP_IDX:
                    r_dir_idx[3] <= i_cfg_data[bardr_pkg::BIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state of the sweep
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bardr_pkg::S_IDLE: if (in_acc) n_state = bardr_pkg::S_RD;
            bardr_pkg::S_RD:   n_state = bardr_pkg::S_UPD;
            bardr_pkg::S_UPD: begin
                if (need_div) begin
                    n_state = bardr_pkg::S_DIV;
                end else begin
                    n_state = last_btn ? bardr_pkg::S_DIR : bardr_pkg::S_RD;
                end
            end
            bardr_pkg::S_DIV: begin
                if (rem_status.done) begin
                    n_state = last_btn ? bardr_pkg::S_DIR : bardr_pkg::S_RD;
                end
            end
            bardr_pkg::S_DIR: if (out_free) n_state = bardr_pkg::S_IDLE;
            default: n_state = bardr_pkg::S_IDLE;
        endcase
    end

    // Advance the sequencer and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bardr_pkg::S_IDLE;
            r_btn       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_btn <= '0;
            end else if (advance) begin
                r_btn <= r_btn + BTN_W'(1);
            end
            if ((r_state == bardr_pkg::S_DIR) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counter memory: read every cycle, write back in the update cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[btn_idx] <= n_cnt;
        end
        r_rd_data <= r_mem[btn_idx];
        r_rd_vld  <= r_vld[btn_idx];
    end

    // Mark entries once written; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[btn_idx] <= 1'b1;
        end
    end

    // Collect the maps and the direction button ages
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held    <= i_held_map;
            r_pressed <= '0;
            r_trig    <= '0;
            r_rep     <= '0;
            r_rel     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_age[k] <= '0;
            end
        end else begin
            if (r_state == bardr_pkg::S_UPD) begin
                if (n_cnt != '0) r_pressed <= r_pressed | bit_mask;
                if (n_cnt == COUNT_WIDTH'(1)) begin
                    r_trig <= r_trig | bit_mask;
                    r_rep  <= r_rep | bit_mask;
                end
                if (rel_now) r_rel <= r_rel | bit_mask;
                for (int k = 0; k < 4; k++) begin
                    if (MATCH_W'(r_btn) == MATCH_W'(r_dir_idx[k])) begin
                        r_age[k] <= n_cnt;
                    end
                end
            end
            if ((r_state == bardr_pkg::S_DIV) && rem_status.done && rem_status.rem_zero) begin
                r_rep <= r_rep | bit_mask;
            end
            if (advance) begin
                r_held <= r_held >> 1;
            end
        end
    end

    // Resolve: none if opposed, else newest press wins, ties to lower code; 8-way diagonal first
    assign a_dn    = (r_age[0] != '0);
    assign a_lf    = (r_age[1] != '0);
    assign a_rt    = (r_age[2] != '0);
    assign a_up    = (r_age[3] != '0);
    assign opposed = (a_dn && a_up) || (a_lf && a_rt);

    assign sel01  = a_dn && (!a_lf || (r_age[0] <= r_age[1]));
    assign nz01   = a_dn || a_lf;
    assign age01  = sel01 ? r_age[0] : r_age[1];
    assign code01 = sel01 ? bardr_pkg::DIR_DOWN
                          : (a_lf ? bardr_pkg::DIR_LEFT : bardr_pkg::DIR_NONE);
    assign sel23  = a_rt && (!a_up || (r_age[2] <= r_age[3]));
    assign nz23   = a_rt || a_up;
    assign age23  = sel23 ? r_age[2] : r_age[3];
    assign code23 = sel23 ? bardr_pkg::DIR_RIGHT
                          : (a_up ? bardr_pkg::DIR_UP : bardr_pkg::DIR_NONE);
    assign selA   = nz01 && (!nz23 || (age01 <= age23));

    always_comb begin
        dir4 = bardr_pkg::DIR_NONE;
        dir8 = bardr_pkg::DIR_NONE;
        if (!opposed) begin
            dir4 = selA ? code01 : code23;
            if (a_up && a_rt) begin
                dir8 = bardr_pkg::DIR_UP_RIGHT;
            end else if (a_up && a_lf) begin
                dir8 = bardr_pkg::DIR_UP_LEFT;
            end else if (a_dn && a_rt) begin
                dir8 = bardr_pkg::DIR_DOWN_RIGHT;
            end else if (a_dn && a_lf) begin
                dir8 = bardr_pkg::DIR_DOWN_LEFT;
            end else begin
                dir8 = dir4;
            end
        end
    end

    // Load the output register once it is free
    always_ff @(posedge i_clk) begin
        if ((r_state == bardr_pkg::S_DIR) && out_free) begin
            r_o_pressed <= r_pressed;
            r_o_trig    <= r_trig;
            r_o_rep     <= r_rep;
            r_o_rel     <= r_rel;
            r_o_dir4    <= dir4;
            r_o_dir8    <= dir8;
        end
    end

    assign o_in_stall      = (r_state != bardr_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pressed_map   = r_o_pressed;
    assign o_triggered_map = r_o_trig;
    assign o_repeated_map  = r_o_rep;
    assign o_released_map  = r_o_rel;
    assign o_dir_four      = r_o_dir4;
    assign o_dir_eight     = r_o_dir8;

    // Checks
    `BARDR_ASSERT_NEXT(a_accept_starts_sweep, in_acc,
        (r_state == bardr_pkg::S_RD) && (r_btn == '0), "request did not start a sweep")
    `BARDR_ASSERT_NOW(a_rem_done_in_div,
        !rem_status.done || (r_state == bardr_pkg::S_DIV), "remainder finished outside wait")
    `BARDR_ASSERT_NOW(a_trig_implies_rep,
        !o_out_valid || ((o_triggered_map & ~o_repeated_map) == '0), "trigger without repeat")
    `BARDR_ASSERT_NOW(a_rel_not_pressed,
        !o_out_valid || ((o_released_map & o_pressed_map) == '0), "released while pressed")

endmodule
